### rtl/mre_pkg.sv
// Shared types and constants of the MySQL resultset end detector.
`default_nettype none

package mre_pkg;

  // Packet type byte values
  localparam logic [7:0] TYPE_OK  = 8'h00;
  localparam logic [7:0] TYPE_EOF = 8'hFE;
  localparam logic [7:0] TYPE_ERR = 8'hFF;

  // Stream status codes
  localparam logic [1:0] STAT_CONTINUE = 2'd0;
  localparam logic [1:0] STAT_END      = 2'd1;
  localparam logic [1:0] STAT_ERROR    = 2'd2;

  // Register map
  localparam int unsigned ADDR_W = 3;
  localparam logic        REG_EOF_EXPECTED = 1'b0;  // word index of the only register
  localparam logic [1:0]  EOF_EXPECTED_RESET = 2'd2;

  // Result of one byte
  typedef struct packed {
    logic       error_packet_seen;
    logic [1:0] eof_seen;
    logic       packet_start;
    logic [1:0] end_status;
    logic       consume_byte;
  } result_t;

endpackage

`default_nettype wire

### rtl/mre_tracker.sv
// Packet framing and resultset phase tracking, one byte per step.
`default_nettype none

module mre_tracker
  import mre_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic [1:0] eof_expected,
  output result_t         result
);

  typedef enum logic [2:0] {
    PH_BODY,
    PH_FINAL,
    PH_OK,
    PH_DONE,
    PH_ERROR
  } phase_t;

  localparam logic [2:0] HDR_TYPE = 3'd4;  // next byte is the type byte

  phase_t      phase, phase_next;
  logic [2:0]  header_index, header_index_next;
  logic [23:0] payload_remaining, payload_remaining_next;
  logic [1:0]  eof_count, eof_count_next;
  logic        error_flag, error_flag_next;

  logic [23:0] rem_dec;
  logic [23:0] rem_hdr;
  logic        hdr_zero_len;
  logic [2:0]  hdr_index_after;
  logic [2:0]  eof_plus;
  logic        consume, start;
  logic [1:0]  status;

  // Shared pieces: decremented length, header byte merge, next EOF count
  always_comb begin
    rem_dec = payload_remaining - 24'd1;
    rem_hdr = payload_remaining;
    hdr_zero_len = 1'b0;
    hdr_index_after = header_index + 3'd1;
    case (header_index)
      3'd0: rem_hdr[7:0]   = payload_remaining[7:0]   | data_byte;
      3'd1: rem_hdr[15:8]  = payload_remaining[15:8]  | data_byte;
      3'd2: rem_hdr[23:16] = payload_remaining[23:16] | data_byte;
      default: begin
        // sequence byte closes the header
        if (payload_remaining == 24'd0) begin
          hdr_zero_len = 1'b1;
          hdr_index_after = 3'd0;
        end else begin
          hdr_index_after = HDR_TYPE;
        end
      end
    endcase
    eof_plus = {1'b0, eof_count} + 3'd1;
  end

  // Next state and result of the current byte
  always_comb begin
    phase_next = phase;
    header_index_next = header_index;
    payload_remaining_next = payload_remaining;
    eof_count_next = eof_count;
    error_flag_next = error_flag;
    consume = 1'b0;
    start = 1'b0;
    status = STAT_CONTINUE;
    case (phase)
      PH_BODY: begin
        consume = 1'b1;
        if (header_index == HDR_TYPE) begin
          header_index_next = 3'd0;
          payload_remaining_next = rem_dec;
          if (data_byte == TYPE_EOF) begin
            if (eof_plus > {1'b0, eof_expected}) begin
              phase_next = PH_ERROR;
            end else begin
              eof_count_next = eof_plus[1:0];
              if (eof_plus == {1'b0, eof_expected}) begin
                phase_next = (rem_dec == 24'd0) ? PH_OK : PH_FINAL;
              end
            end
          end else if (data_byte == TYPE_ERR) begin
            error_flag_next = 1'b1;
            phase_next = (rem_dec == 24'd0) ? PH_OK : PH_FINAL;
          end else if (data_byte == TYPE_OK && eof_count != 2'd1) begin
            phase_next = PH_ERROR;
          end
        end else if (header_index == 3'd0 && payload_remaining != 24'd0) begin
          payload_remaining_next = rem_dec;
        end else begin
          start = (header_index == 3'd0);
          payload_remaining_next = rem_hdr;
          header_index_next = hdr_index_after;
        end
      end
      PH_FINAL: begin
        consume = 1'b1;
        // drain the rest of the closing packet
        if (payload_remaining <= 24'd1) begin
          payload_remaining_next = 24'd0;
          phase_next = PH_OK;
          header_index_next = 3'd0;
        end else begin
          payload_remaining_next = rem_dec;
        end
      end
      PH_OK: begin
        if (header_index == HDR_TYPE) begin
          header_index_next = 3'd0;
          payload_remaining_next = rem_dec;
          if (data_byte != TYPE_OK) begin
            phase_next = PH_ERROR;
          end else if (rem_dec == 24'd0) begin
            phase_next = PH_DONE;
          end
        end else if (header_index == 3'd0 && payload_remaining != 24'd0) begin
          payload_remaining_next = rem_dec;
          if (rem_dec == 24'd0) begin
            phase_next = PH_DONE;
          end
        end else begin
          start = (header_index == 3'd0);
          payload_remaining_next = rem_hdr;
          header_index_next = hdr_index_after;
          if (hdr_zero_len) begin
            phase_next = PH_ERROR;
          end
        end
        if (phase_next == PH_DONE) begin
          status = STAT_END;
        end
      end
      default: begin
        // trailing byte after the end, or sticky error
        phase_next = PH_ERROR;
      end
    endcase
    if (phase_next == PH_ERROR) begin
      consume = 1'b0;
      start = 1'b0;
      status = STAT_ERROR;
    end
  end

  assign result = '{
    error_packet_seen: error_flag_next,
    eof_seen:          eof_count_next,
    packet_start:      start,
    end_status:        status,
    consume_byte:      consume
  };

  // Hold state between bytes, advance on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BODY;
      header_index <= 3'd0;
      payload_remaining <= 24'd0;
      eof_count <= 2'd0;
      error_flag <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      header_index <= header_index_next;
      payload_remaining <= payload_remaining_next;
      eof_count <= eof_count_next;
      error_flag <= error_flag_next;
    end
  end

  // Protocol error is sticky
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR |=> phase == PH_ERROR)
    else $error("error phase left without reset");

  // Header index never passes the type-byte marker
  assert property (@(posedge clk) disable iff (rst)
    header_index <= HDR_TYPE)
    else $error("header index out of range");

  // A normal end moves the tracker into the done phase
  assert property (@(posedge clk) disable iff (rst)
    step && result.end_status == STAT_END |=> phase == PH_DONE)
    else $error("normal end reported without entering done phase");

  // Type byte only follows a header with a nonzero length
  assert property (@(posedge clk) disable iff (rst)
    header_index == HDR_TYPE |-> payload_remaining != 24'd0)
    else $error("type byte pending on a zero-length packet");

endmodule

`default_nettype wire

### rtl/mysql_resultset_end_detector.sv
// Top level of the MySQL resultset end detector: stream ports, register, pipeline.
// Usage:
//   The slave stream (s_tvalid/s_tready/s_tdata) carries the raw server response,
//   one byte per transfer. The master stream (m_tvalid/m_tready/m_tdata) returns
//   one result per input byte, in order: consume flag, status (continue, normal
//   end, protocol error), packet start flag, EOF count and ERR-packet flag.
//   The APB port holds eof_packets_expected at byte address 0 (reset value 2);
//   write it only while no byte is in flight.
// Pipeline:
//   A byte taken into the input register is processed by the tracker once the
//   result register is free or drained; its result is registered and shown on
//   m_tvalid. One byte per cycle is sustained while m_tready stays high: the framing
//   state update is a single short step between the input and result registers.
// Reset:
//   rst (synchronous, active high) empties both registers, returns framing to the
//   start of the body with no EOF counted and no error, and restores the register.
// Stall:
//   When m_tready is low the result register holds; the input register still
//   takes one more byte, after which s_tready drops until the result is taken.
`default_nettype none

module mysql_resultset_end_detector
  import mre_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // input stream
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] data_byte
  // result stream
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata,   // [0] consume_byte, [2:1] end_status,
                                            // [3] packet_start, [5:4] eof_seen,
                                            // [6] error_packet_seen, [7] zero
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic       eof_expected;
  logic [1:0] eof_expected_reg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_valid;
  result_t    out_result;
  result_t    step_result;
  logic       advance;

  // Register write and read
  assign pready = 1'b1;
  assign eof_expected = (paddr[ADDR_W-1] == REG_EOF_EXPECTED);

  always_ff @(posedge clk) begin
    if (rst) begin
      eof_expected_reg <= EOF_EXPECTED_RESET;
    end else if (psel && penable && pwrite && pready && eof_expected) begin
      eof_expected_reg <= pwdata[1:0];
    end
  end

  assign prdata = eof_expected ? {30'd0, eof_expected_reg} : 32'd0;

  // Pipeline control: process when the result register is free or drained
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  mre_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .data_byte    (in_byte),
    .eof_expected (eof_expected_reg),
    .result       (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_result};

  // A held result is not overwritten while the receiver stalls
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |-> !advance)
    else $error("result overwritten during stall");

  // Input side stalls only with a byte waiting in the input register
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid && !m_tready)
    else $error("input stalled without cause");

  // Every processed byte produces a valid result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed byte produced no result");

endmodule

`default_nettype wire
